### rtl/cwt_pkg.sv
// Package for the completion window tracker: field widths, operation codes,
// controller states and the structs passed between the tracker's modules.
// No dependencies.
`timescale 1ns / 1ps

package cwt_pkg;

   // Channel field widths
   localparam int FIELD_W = 32;
   localparam int OP_W    = 3;

   // Parameter defaults and reset value of the first valid id
   localparam int DEF_WINDOW  = 64;
   localparam int DEF_ID_BITS = 32;
   localparam int FVI_RESET   = 1;

   // Operation codes carried on the request channel
   typedef enum logic [OP_W-1:0] {
      OP_CLEAR    = 3'd0,
      OP_QUERY    = 3'd1,
      OP_START    = 3'd2,
      OP_ABORT    = 3'd3,
      OP_COMPLETE = 3'd4,
      OP_RECOVER  = 3'd5,
      OP_NEXT     = 3'd6
   } op_type;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_QUERY_RD,
      ST_SCAN,
      ST_NEXT_CHK,
      ST_WIPE,
      ST_PUSH
   } state_type;

   // What a window scan looks for
   typedef enum logic [1:0] {
      SCAN_COMPLETE,
      SCAN_RECOVER,
      SCAN_NEXT
   } scan_mode_type;

   // Id classification against the low mark, from the decoder
   typedef struct packed {
      logic above;
      logic inwin;
      logic below_first;
      logic off_zero;
      logic oow;
   } dec_flags_type;

   // One result item
   typedef struct packed {
      logic               should_process;
      logic [FIELD_W-1:0] next_id;
      logic               next_found;
      logic [FIELD_W-1:0] low_mark;
      logic               out_of_window;
   } rsp_type;

endpackage

### rtl/cwt_req_if.sv
// Request channel of the completion window tracker: valid/ready and one item.
// Depends on cwt_pkg.
`timescale 1ns / 1ps

interface cwt_req_if;
   import cwt_pkg::*;

   logic               valid;
   logic               ready;
   logic [OP_W-1:0]    operation;
   logic [FIELD_W-1:0] item_id;

   modport source (output valid, output operation, output item_id, input ready);
   modport sink   (input valid, input operation, input item_id, output ready);

endinterface

### rtl/cwt_rsp_if.sv
// Response channel of the completion window tracker: valid/ready and one result.
// Depends on cwt_pkg.
`timescale 1ns / 1ps

interface cwt_rsp_if;
   import cwt_pkg::*;

   logic               valid;
   logic               ready;
   logic               should_process;
   logic [FIELD_W-1:0] next_id;
   logic               next_found;
   logic [FIELD_W-1:0] low_mark;
   logic               out_of_window;

   modport source (output valid, output should_process, output next_id,
                   output next_found, output low_mark, output out_of_window,
                   input ready);
   modport sink   (input valid, input should_process, input next_id,
                   input next_found, input low_mark, input out_of_window,
                   output ready);

endinterface

### rtl/cwt_bit_ram.sv
// One-bit-wide synchronous RAM, one write and one read port, registered read.
// Holds one window bitmap of the tracker; no dependencies beyond cwt_pkg defaults.
`timescale 1ns / 1ps

module cwt_bit_ram #(
   parameter int  DEPTH = cwt_pkg::DEF_WINDOW,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic          wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic          rd_data
);

   logic mem [DEPTH];
   logic rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port, registered
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/cwt_id_decode.sv
// Request capture and id classification against the low mark and window.
// Depends on cwt_pkg.
`timescale 1ns / 1ps

module cwt_id_decode #(
   parameter int  WINDOW  = cwt_pkg::DEF_WINDOW,
   parameter int  ID_BITS = cwt_pkg::DEF_ID_BITS,
   localparam int AW      = $clog2(WINDOW),
   localparam int PW      = $clog2(WINDOW + 1),
   localparam int CW      = (ID_BITS > PW) ? ID_BITS : PW
) (
   input  logic                       clock,
   input  logic                       accept,
   input  logic [cwt_pkg::OP_W-1:0]   operation,
   input  logic [ID_BITS-1:0]         item_id,
   input  logic [ID_BITS-1:0]         low_mark,
   input  logic [ID_BITS-1:0]         first_valid_id,
   output cwt_pkg::op_type            dec_op,
   output logic [ID_BITS-1:0]         dec_id,
   output cwt_pkg::dec_flags_type     dec_flags,
   output logic [AW-1:0]              dec_off
);
   import cwt_pkg::*;

   op_type              op;
   logic [ID_BITS-1:0]  off;
   dec_flags_type       flags;

   op_type              op_ff;
   logic [ID_BITS-1:0]  id_ff;
   dec_flags_type       flags_ff;
   logic [AW-1:0]       off_ff;

   // Classify the id relative to the low mark
   always_comb begin
      op                = op_type'(operation);
      off               = item_id - low_mark;
      flags.above       = (item_id >= low_mark);
      flags.inwin       = flags.above && (CW'(off) < CW'(WINDOW));
      flags.below_first = (item_id < first_valid_id);
      flags.off_zero    = (off == '0);
      flags.oow         = (op inside {OP_QUERY, OP_START, OP_ABORT, OP_COMPLETE})
                          && flags.above && !flags.inwin;
   end

   // Hold the item and its classification for the controller
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= op;
         id_ff    <= item_id;
         flags_ff <= flags;
         off_ff   <= AW'(off);
      end
   end

   assign dec_op    = op_ff;
   assign dec_id    = id_ff;
   assign dec_flags = flags_ff;
   assign dec_off   = off_ff;

endmodule

### rtl/cwt_ctrl.sv
// Tracker controller: low mark and highest-seen state, window pointer, and the
// sequencer that reads, scans and rewrites the done and busy RAMs. Depends on cwt_pkg.
`timescale 1ns / 1ps

module cwt_ctrl #(
   parameter int  WINDOW  = cwt_pkg::DEF_WINDOW,
   parameter int  ID_BITS = cwt_pkg::DEF_ID_BITS,
   localparam int AW      = $clog2(WINDOW),
   localparam int PW      = $clog2(WINDOW + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  cwt_pkg::op_type         dec_op,
   input  logic [ID_BITS-1:0]      dec_id,
   input  cwt_pkg::dec_flags_type  dec_flags,
   input  logic [AW-1:0]           dec_off,
   input  logic [ID_BITS-1:0]      first_valid_id,
   output logic                    req_ready,
   output logic [ID_BITS-1:0]      low_mark,
   output logic                    res_valid,
   input  logic                    res_taken,
   output cwt_pkg::rsp_type        res,
   output logic [AW-1:0]           rd_addr,
   input  logic                    done_rd,
   input  logic                    busy_rd,
   output logic                    done_we,
   output logic [AW-1:0]           done_wa,
   output logic                    done_wd,
   output logic                    busy_we,
   output logic [AW-1:0]           busy_wa,
   output logic                    busy_wd
);
   import cwt_pkg::*;

   state_type           state_ff, state_in;
   logic [ID_BITS-1:0]  low_mark_ff, low_mark_in;
   logic [ID_BITS-1:0]  hs_ff, hs_in;
   logic                hsv_ff, hsv_in;
   logic [AW-1:0]       ptr_ff, ptr_in;
   logic [PW-1:0]       scan_pos_ff, scan_pos_in;
   logic                rd_valid_ff, rd_valid_in;
   logic [AW-1:0]       rd_pos_ff, rd_pos_in;
   logic [AW-1:0]       rd_wa_ff, rd_wa_in;
   scan_mode_type       mode_ff, mode_in;
   logic [AW-1:0]       top_ff, top_in;
   logic                top_found_ff, top_found_in;
   logic                cond_ff, cond_in;
   logic [PW-1:0]       wipe_pos_ff, wipe_pos_in;
   logic [PW-1:0]       wipe_end_ff, wipe_end_in;
   logic                wipe_busy_ff, wipe_busy_in;
   logic                wipe_adv_ff, wipe_adv_in;
   logic                wipe_push_ff, wipe_push_in;
   logic [ID_BITS-1:0]  cand_ff, cand_in;
   logic                sp_ff, sp_in;
   logic [ID_BITS-1:0]  nid_ff, nid_in;
   logic                nfound_ff, nfound_in;
   logic                oow_ff, oow_in;

   logic [AW-1:0]       item_addr;
   logic [AW-1:0]       scan_addr;
   logic [AW-1:0]       wipe_addr;
   logic [PW-1:0]       wipe_next;
   logic [PW-1:0]       jump;
   logic                stop;
   logic                issue;
   logic                scan_end;

   // Window position to RAM address: pointer plus position, wrapped once
   function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                              input logic [PW-1:0] step);
      logic [AW:0] sum;
      sum = {1'b0, base} + (AW+1)'(step);
      if (sum >= (AW+1)'(WINDOW)) begin
         sum = sum - (AW+1)'(WINDOW);
      end
      return sum[AW-1:0];
   endfunction

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_WIPE;
         low_mark_ff  <= ID_BITS'(FVI_RESET);
         hs_ff        <= '0;
         hsv_ff       <= 1'b0;
         ptr_ff       <= '0;
         scan_pos_ff  <= '0;
         rd_valid_ff  <= 1'b0;
         mode_ff      <= SCAN_COMPLETE;
         top_found_ff <= 1'b0;
         cond_ff      <= 1'b0;
         wipe_pos_ff  <= '0;
         wipe_end_ff  <= PW'(WINDOW);
         wipe_busy_ff <= 1'b1;
         wipe_adv_ff  <= 1'b0;
         wipe_push_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         low_mark_ff  <= low_mark_in;
         hs_ff        <= hs_in;
         hsv_ff       <= hsv_in;
         ptr_ff       <= ptr_in;
         scan_pos_ff  <= scan_pos_in;
         rd_valid_ff  <= rd_valid_in;
         mode_ff      <= mode_in;
         top_found_ff <= top_found_in;
         cond_ff      <= cond_in;
         wipe_pos_ff  <= wipe_pos_in;
         wipe_end_ff  <= wipe_end_in;
         wipe_busy_ff <= wipe_busy_in;
         wipe_adv_ff  <= wipe_adv_in;
         wipe_push_ff <= wipe_push_in;
      end
   end

   // Scan payload and result fields
   always_ff @(posedge clock) begin
      rd_pos_ff <= rd_pos_in;
      rd_wa_ff  <= rd_wa_in;
      top_ff    <= top_in;
      cand_ff   <= cand_in;
      sp_ff     <= sp_in;
      nid_ff    <= nid_in;
      nfound_ff <= nfound_in;
      oow_ff    <= oow_in;
   end

   // Addresses and scan decisions
   always_comb begin
      item_addr = wrap_add(ptr_ff, PW'(dec_off));
      scan_addr = wrap_add(ptr_ff, scan_pos_ff);
      wipe_addr = wrap_add(ptr_ff, wipe_pos_ff);
      wipe_next = wipe_pos_ff + PW'(1);
      stop      = rd_valid_ff &&
                  (((mode_ff == SCAN_COMPLETE) && !done_rd) ||
                   ((mode_ff == SCAN_NEXT) && !done_rd && !busy_rd));
      issue     = !stop && (scan_pos_ff != PW'(WINDOW));
      scan_end  = stop || (!rd_valid_ff && (scan_pos_ff == PW'(WINDOW)));
      jump      = stop ? PW'(rd_pos_ff) : PW'(WINDOW);
   end

   // Sequencer: next state, RAM commands and result
   always_comb begin
      state_in     = state_ff;
      low_mark_in  = low_mark_ff;
      hs_in        = hs_ff;
      hsv_in       = hsv_ff;
      ptr_in       = ptr_ff;
      scan_pos_in  = scan_pos_ff;
      rd_valid_in  = 1'b0;
      rd_pos_in    = rd_pos_ff;
      rd_wa_in     = rd_wa_ff;
      mode_in      = mode_ff;
      top_in       = top_ff;
      top_found_in = top_found_ff;
      cond_in      = cond_ff;
      wipe_pos_in  = wipe_pos_ff;
      wipe_end_in  = wipe_end_ff;
      wipe_busy_in = wipe_busy_ff;
      wipe_adv_in  = wipe_adv_ff;
      wipe_push_in = wipe_push_ff;
      cand_in      = cand_ff;
      sp_in        = sp_ff;
      nid_in       = nid_ff;
      nfound_in    = nfound_ff;
      oow_in       = oow_ff;
      req_ready    = 1'b0;
      res_valid    = 1'b0;
      rd_addr      = item_addr;
      done_we      = 1'b0;
      done_wa      = item_addr;
      done_wd      = 1'b0;
      busy_we      = 1'b0;
      busy_wa      = item_addr;
      busy_wd      = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (accept) begin
               state_in = ST_EXEC;
            end
         end

         ST_EXEC: begin
            sp_in     = 1'b0;
            nid_in    = '0;
            nfound_in = 1'b0;
            oow_in    = dec_flags.oow;
            state_in  = ST_PUSH;
            case (dec_op)
               OP_CLEAR: begin
                  hs_in        = '0;
                  hsv_in       = 1'b0;
                  low_mark_in  = first_valid_id;
                  ptr_in       = '0;
                  wipe_pos_in  = '0;
                  wipe_end_in  = PW'(WINDOW);
                  wipe_busy_in = 1'b1;
                  wipe_adv_in  = 1'b0;
                  wipe_push_in = 1'b1;
                  state_in     = ST_WIPE;
               end
               OP_QUERY: begin
                  // read the done bit; note the id as seen
                  if (!hsv_ff || (dec_id > hs_ff)) begin
                     hs_in  = dec_id;
                     hsv_in = 1'b1;
                  end
                  state_in = ST_QUERY_RD;
               end
               OP_START: begin
                  busy_we = dec_flags.inwin;
                  busy_wd = 1'b1;
               end
               OP_ABORT: begin
                  busy_we = dec_flags.inwin;
                  busy_wd = 1'b0;
               end
               OP_COMPLETE: begin
                  if (!dec_flags.below_first && dec_flags.inwin) begin
                     busy_we = 1'b1;
                     busy_wd = 1'b0;
                     if (!dec_flags.off_zero) begin
                        done_we = 1'b1;
                        done_wd = 1'b1;
                     end else begin
                        // mark reached: scan the done run above it
                        mode_in     = SCAN_COMPLETE;
                        scan_pos_in = PW'(1);
                        state_in    = ST_SCAN;
                     end
                  end
               end
               OP_RECOVER: begin
                  mode_in      = SCAN_RECOVER;
                  scan_pos_in  = '0;
                  top_found_in = 1'b0;
                  cond_in      = !hsv_ff || (low_mark_ff <= hs_ff);
                  state_in     = ST_SCAN;
               end
               OP_NEXT: begin
                  mode_in     = SCAN_NEXT;
                  scan_pos_in = '0;
                  state_in    = ST_SCAN;
               end
               default: begin
                  state_in = ST_PUSH;
               end
            endcase
         end

         ST_QUERY_RD: begin
            sp_in    = dec_flags.above && (!dec_flags.inwin || !done_rd);
            state_in = ST_PUSH;
         end

         ST_SCAN: begin
            // drop each done id that the low mark moves past
            if (rd_valid_ff && (mode_ff == SCAN_COMPLETE) && done_rd) begin
               done_we = 1'b1;
               done_wa = rd_wa_ff;
               done_wd = 1'b0;
               busy_we = 1'b1;
               busy_wa = rd_wa_ff;
               busy_wd = 1'b0;
            end
            // remember the highest done position
            if (rd_valid_ff && (mode_ff == SCAN_RECOVER) && done_rd) begin
               top_in       = rd_pos_ff;
               top_found_in = 1'b1;
            end
            // issue the next read ahead of the data
            rd_addr = scan_addr;
            if (issue) begin
               rd_valid_in = 1'b1;
               rd_pos_in   = AW'(scan_pos_ff);
               rd_wa_in    = scan_addr;
               scan_pos_in = scan_pos_ff + PW'(1);
            end
            if (scan_end) begin
               rd_valid_in = 1'b0;
               case (mode_ff)
                  SCAN_COMPLETE: begin
                     ptr_in      = wrap_add(ptr_ff, jump);
                     low_mark_in = low_mark_ff + ID_BITS'(jump);
                     state_in    = ST_PUSH;
                  end
                  SCAN_NEXT: begin
                     cand_in  = low_mark_ff + ID_BITS'(jump);
                     state_in = ST_NEXT_CHK;
                  end
                  SCAN_RECOVER: begin
                     if (top_found_ff) begin
                        wipe_pos_in  = '0;
                        wipe_end_in  = PW'(top_ff) + PW'(1);
                        wipe_busy_in = cond_ff;
                        wipe_adv_in  = cond_ff;
                        wipe_push_in = 1'b1;
                        state_in     = ST_WIPE;
                     end else begin
                        state_in = ST_PUSH;
                     end
                  end
                  default: begin
                     state_in = ST_PUSH;
                  end
               endcase
            end
         end

         ST_NEXT_CHK: begin
            if (hsv_ff && (cand_ff <= hs_ff)) begin
               nfound_in = 1'b1;
               nid_in    = cand_ff;
            end
            state_in = ST_PUSH;
         end

         ST_WIPE: begin
            // clear one entry a cycle from the bottom of the window
            done_we     = 1'b1;
            done_wa     = wipe_addr;
            done_wd     = 1'b0;
            busy_we     = wipe_busy_ff;
            busy_wa     = wipe_addr;
            busy_wd     = 1'b0;
            wipe_pos_in = wipe_next;
            if (wipe_next == wipe_end_ff) begin
               if (wipe_adv_ff) begin
                  ptr_in      = wrap_add(ptr_ff, wipe_end_ff);
                  low_mark_in = low_mark_ff + ID_BITS'(wipe_end_ff);
               end
               state_in = wipe_push_ff ? ST_PUSH : ST_IDLE;
            end
         end

         ST_PUSH: begin
            res_valid = 1'b1;
            if (res_taken) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result item
   always_comb begin
      res.should_process = sp_ff;
      res.next_id        = FIELD_W'(nid_ff);
      res.next_found     = nfound_ff;
      res.low_mark       = FIELD_W'(low_mark_ff);
      res.out_of_window  = oow_ff;
   end

   assign low_mark = low_mark_ff;

endmodule

### rtl/completion_window_tracker.sv
// Completion window tracker: low mark plus done/busy window bitmaps kept in two RAMs.
// Start, abort, complete off the mark and no-op go from exec straight to the result;
// query reads the done bit first. Ready returns the cycle after the result is handed
// to the output. Complete at the mark scans the done run; next scans the run of done
// or busy ids; recover scans the whole window, then wipes up to its highest done
// entry, if any; clear wipes the whole window.
// Reset: synchronous; a clearing pass over the window follows, with req ready low.
`timescale 1ns / 1ps

module completion_window_tracker #(
   parameter int WINDOW  = cwt_pkg::DEF_WINDOW,
   parameter int ID_BITS = cwt_pkg::DEF_ID_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   cwt_req_if.sink                       req_chan,
   cwt_rsp_if.source                     rsp_chan,
   input  logic                          csr_wr_en,
   input  logic [cwt_pkg::FIELD_W-1:0]   csr_wr_data
);
   import cwt_pkg::*;

   localparam int AW = $clog2(WINDOW);

   logic [ID_BITS-1:0]  fvi_ff;
   rsp_type             rsp_ff;
   logic                rsp_valid_ff, rsp_valid_in;

   logic                req_ready;
   logic                accept;
   logic [ID_BITS-1:0]  low_mark;
   logic                res_valid;
   logic                res_taken;
   rsp_type             res;

   op_type              dec_op;
   logic [ID_BITS-1:0]  dec_id;
   dec_flags_type       dec_flags;
   logic [AW-1:0]       dec_off;

   logic [AW-1:0]       rd_addr;
   logic                done_rd, busy_rd;
   logic                done_we, done_wd, busy_we, busy_wd;
   logic [AW-1:0]       done_wa, busy_wa;

   assign accept         = req_chan.valid && req_ready;
   assign req_chan.ready = req_ready;

   // First valid id register
   always_ff @(posedge clock) begin
      if (reset) begin
         fvi_ff <= ID_BITS'(FVI_RESET);
      end else if (csr_wr_en) begin
         fvi_ff <= ID_BITS'(csr_wr_data);
      end
   end

   cwt_id_decode #(
      .WINDOW  (WINDOW),
      .ID_BITS (ID_BITS)
   ) u_decode (
      .clock          (clock),
      .accept         (accept),
      .operation      (req_chan.operation),
      .item_id        (ID_BITS'(req_chan.item_id)),
      .low_mark       (low_mark),
      .first_valid_id (fvi_ff),
      .dec_op         (dec_op),
      .dec_id         (dec_id),
      .dec_flags      (dec_flags),
      .dec_off        (dec_off)
   );

   cwt_ctrl #(
      .WINDOW  (WINDOW),
      .ID_BITS (ID_BITS)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .dec_op         (dec_op),
      .dec_id         (dec_id),
      .dec_flags      (dec_flags),
      .dec_off        (dec_off),
      .first_valid_id (fvi_ff),
      .req_ready      (req_ready),
      .low_mark       (low_mark),
      .res_valid      (res_valid),
      .res_taken      (res_taken),
      .res            (res),
      .rd_addr        (rd_addr),
      .done_rd        (done_rd),
      .busy_rd        (busy_rd),
      .done_we        (done_we),
      .done_wa        (done_wa),
      .done_wd        (done_wd),
      .busy_we        (busy_we),
      .busy_wa        (busy_wa),
      .busy_wd        (busy_wd)
   );

   cwt_bit_ram #(
      .DEPTH (WINDOW)
   ) u_done_ram (
      .clock   (clock),
      .wr_en   (done_we),
      .wr_addr (done_wa),
      .wr_data (done_wd),
      .rd_addr (rd_addr),
      .rd_data (done_rd)
   );

   cwt_bit_ram #(
      .DEPTH (WINDOW)
   ) u_busy_ram (
      .clock   (clock),
      .wr_en   (busy_we),
      .wr_addr (busy_wa),
      .wr_data (busy_wd),
      .rd_addr (rd_addr),
      .rd_data (busy_rd)
   );

   // Output register: take a result whenever the slot is empty or draining
   assign res_taken = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_valid && res_taken) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_taken) begin
         rsp_ff <= res;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.should_process = rsp_ff.should_process;
   assign rsp_chan.next_id        = rsp_ff.next_id;
   assign rsp_chan.next_found     = rsp_ff.next_found;
   assign rsp_chan.low_mark       = rsp_ff.low_mark;
   assign rsp_chan.out_of_window  = rsp_ff.out_of_window;

   // One item in work at a time
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready)
      else $error("tracker took a second item while one was in work");

   // Low mark moves only while an item is in work
   a_mark_idle: assert property (@(posedge clock) disable iff (reset)
      (req_ready && $past(req_ready)) |-> $stable(low_mark))
      else $error("low mark changed while the tracker was idle");

   // A next result never carries query or window flags
   a_next_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |->
         !(rsp_chan.next_found && (rsp_chan.should_process || rsp_chan.out_of_window)))
      else $error("result mixes next-found with query or window flags");

endmodule

### verif/completion_window_tracker_test.sv
// Self-checking testbench for completion_window_tracker: drives ops, predicts each result.
// Depends on cwt_pkg, cwt_req_if, cwt_rsp_if and the tracker RTL.
`timescale 1ns / 1ps

module completion_window_tracker_test;
   import cwt_pkg::*;

   localparam int CLK_PERIOD  = 10;
   localparam int WIN         = DEF_WINDOW;
   localparam int WIN_AW      = $clog2(WIN);
   localparam int PHASE_ITEMS = 330;
   localparam int QUIET_LIMIT = 2000;
   localparam int SETTLE_CYC  = 200;
   localparam int MAX_REPORTS = 10;

   // Operation 7 is not in the enum: a no-op that reports the mark
   localparam logic [OP_W-1:0] OP_NOP = 3'd7;

   typedef struct packed {
      logic [OP_W-1:0]    opc;
      logic [FIELD_W-1:0] id;
   } tracker_req_type;

   logic               clock       = 1'b0;
   logic               reset       = 1'b1;
   logic               csr_wr_en   = 1'b0;
   logic [FIELD_W-1:0] csr_wr_data = '0;

   cwt_req_if req_chan ();
   cwt_rsp_if rsp_chan ();

   completion_window_tracker u_top (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Tracker shadow state
   logic [FIELD_W-1:0] first_id_cfg;
   logic [FIELD_W-1:0] mark;
   logic [FIELD_W-1:0] top_seen;
   logic               seen_any;
   logic [WIN-1:0]     done_map;
   logic [WIN-1:0]     busy_map;

   tracker_req_type pending_req [$];
   rsp_type         expected_rsp [$];

   int  error_count = 0;
   int  quiet_cycles = 0;
   int  send_gap = 0;
   int  recv_gap = 0;
   bit  send_idle_on = 1'b0;
   bit  recv_idle_on = 1'b0;
   int  phase_items;

   initial begin
      req_chan.valid     = 1'b0;
      req_chan.operation = '0;
      req_chan.item_id   = '0;
      rsp_chan.ready     = 1'b0;
   end

   function automatic void clear_tracker();
      top_seen = '0;
      seen_any = 1'b0;
      mark     = first_id_cfg;
      done_map = '0;
      busy_map = '0;
   endfunction

   // Apply one op to the shadow state and return the result it must give
   function automatic rsp_type track_step(logic [OP_W-1:0] opc, logic [FIELD_W-1:0] id);
      rsp_type            r;
      logic               above;
      logic               inwin;
      logic [FIELD_W-1:0] off;
      logic [WIN_AW-1:0]  pos;
      logic [FIELD_W-1:0] cand;
      int                 j;
      int                 top;
      r     = '0;
      above = (id >= mark);
      off   = id - mark;
      pos   = off[WIN_AW-1:0];
      inwin = above && (off < WIN);
      if (opc >= OP_QUERY && opc <= OP_COMPLETE && above && !inwin)
         r.out_of_window = 1'b1;
      case (opc)
         OP_CLEAR: clear_tracker();
         OP_QUERY: begin
            if (!above)
               r.should_process = 1'b0;
            else if (inwin)
               r.should_process = !done_map[pos];
            else
               r.should_process = 1'b1;
            if (!seen_any || id > top_seen) begin
               top_seen = id;
               seen_any = 1'b1;
            end
         end
         OP_START: begin
            if (inwin)
               busy_map[pos] = 1'b1;
         end
         OP_ABORT: begin
            if (inwin)
               busy_map[pos] = 1'b0;
         end
         OP_COMPLETE: begin
            if (id >= first_id_cfg && inwin) begin
               busy_map[pos] = 1'b0;
               if (off == 0) begin
                  // advance the mark past every contiguous done id
                  j = 1;
                  while (j < WIN && done_map[j[WIN_AW-1:0]])
                     j++;
                  done_map = done_map >> j;
                  busy_map = busy_map >> j;
                  mark     = mark + FIELD_W'(j);
               end else begin
                  done_map[pos] = 1'b1;
               end
            end
         end
         OP_RECOVER: begin
            top = -1;
            for (int i = 0; i < WIN; i++)
               if (done_map[i[WIN_AW-1:0]])
                  top = i;
            if (top >= 0 && (!seen_any || mark <= top_seen)) begin
               busy_map = busy_map >> (top + 1);
               mark     = mark + FIELD_W'(top + 1);
            end
            done_map = '0;
         end
         OP_NEXT: begin
            j = 0;
            while (j < WIN && (done_map[j[WIN_AW-1:0]] || busy_map[j[WIN_AW-1:0]]))
               j++;
            cand = mark + FIELD_W'(j);
            if (seen_any && cand <= top_seen) begin
               r.next_found = 1'b1;
               r.next_id    = cand;
            end
         end
         default: ;
      endcase
      r.low_mark = mark;
      return r;
   endfunction

   // Request driver: present the oldest pending item, idle in short bursts
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            expected_rsp.push_back(track_step(req_chan.operation, req_chan.item_id));
            pending_req.delete(0);
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_chan.valid <= 1'b0;
            end else if (pending_req.size() == 0) begin
               req_chan.valid <= 1'b0;
            end else if (send_idle_on && $urandom_range(4, 0) == 0) begin
               send_gap = $urandom_range(2, 0);
               req_chan.valid <= 1'b0;
            end else begin
               req_chan.valid     <= 1'b1;
               req_chan.operation <= pending_req[0].opc;
               req_chan.item_id   <= pending_req[0].id;
            end
         end
      end
   end

   task automatic note_mismatch(string field, logic [FIELD_W-1:0] want,
                                logic [FIELD_W-1:0] got);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("%0t: %s mismatch: expected %h, got %h", $time, field, want, got);
   endtask

   task automatic check_field(string field, logic [FIELD_W-1:0] want,
                              logic [FIELD_W-1:0] got);
      if (want !== got)
         note_mismatch(field, want, got);
   endtask

   // Result monitor: compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_rsp.size() == 0) begin
               note_mismatch("unexpected result, low_mark", '0, rsp_chan.low_mark);
            end else begin
               want = expected_rsp.pop_front();
               check_field("should_process", want.should_process, rsp_chan.should_process);
               check_field("next_id", want.next_id, rsp_chan.next_id);
               check_field("next_found", want.next_found, rsp_chan.next_found);
               check_field("low_mark", want.low_mark, rsp_chan.low_mark);
               check_field("out_of_window", want.out_of_window, rsp_chan.out_of_window);
            end
         end
         if (recv_gap > 0) begin
            recv_gap--;
            rsp_chan.ready <= 1'b0;
         end else if (recv_idle_on && $urandom_range(4, 0) == 0) begin
            recv_gap = $urandom_range(2, 0);
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // Count cycles in which neither channel moves an item
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin : watchdog
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("TEST FAILED");
      $finish;
   end

   // Queue one item, keeping only a few ahead of the driver
   task automatic queue_item(logic [OP_W-1:0] opc, logic [FIELD_W-1:0] id, bit counted = 1'b1);
      tracker_req_type it;
      do
         @(negedge clock);
      while (pending_req.size() >= 3);
      it.opc = opc;
      it.id  = id;
      pending_req.push_back(it);
      if (counted)
         phase_items++;
   endtask

   task automatic wait_drained();
      do
         @(negedge clock);
      while (pending_req.size() != 0 || expected_rsp.size() != 0 || !req_chan.ready);
   endtask

   task automatic wait_sent();
      while (pending_req.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_first_id(logic [FIELD_W-1:0] value);
      wait_drained();
      @(posedge clock);
      csr_wr_en    <= 1'b1;
      csr_wr_data  <= value;
      first_id_cfg = value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Well-formed run: query, start, then complete a block of ids in shuffled order
   task automatic run_batch();
      logic [FIELD_W-1:0] base;
      int unsigned        n;
      int unsigned        slot [8];
      int unsigned        pick;
      int unsigned        tmp;
      wait_sent();
      base = mark;
      if ($urandom_range(9, 0) < 3)
         base = base + $urandom_range(3, 1);
      n = $urandom_range(8, 1);
      for (int k = 0; k < n; k++)
         slot[k] = k;
      for (int k = n - 1; k > 0; k--) begin
         pick       = $urandom_range(k, 0);
         tmp        = slot[k];
         slot[k]    = slot[pick];
         slot[pick] = tmp;
      end
      for (int k = 0; k < n; k++)
         queue_item(OP_QUERY, base + slot[k]);
      if ($urandom_range(1, 0))
         queue_item(OP_NEXT, $urandom);
      for (int k = 0; k < n; k++)
         queue_item(OP_START, base + k);
      if ($urandom_range(3, 0) == 0) begin
         queue_item(OP_ABORT, base + slot[0]);
         queue_item(OP_NEXT, $urandom);
      end
      for (int k = 0; k < n; k++)
         queue_item(OP_COMPLETE, base + slot[k]);
      if ($urandom_range(9, 0) == 0)
         queue_item(OP_RECOVER, $urandom);
      queue_item(OP_NEXT, $urandom);
   endtask

   // Fill the whole window with busy ids, look for the next id, then retire them all
   task automatic fill_window();
      logic [FIELD_W-1:0] base;
      int unsigned        slot [WIN];
      int unsigned        pick;
      int unsigned        tmp;
      wait_drained();
      base = mark;
      queue_item(OP_QUERY, base + WIN + 5);
      for (int k = 0; k < WIN; k++)
         queue_item(OP_START, base + k);
      queue_item(OP_NEXT, $urandom);
      for (int k = 0; k < WIN; k++)
         slot[k] = k;
      for (int k = WIN - 1; k > 0; k--) begin
         pick       = $urandom_range(k, 0);
         tmp        = slot[k];
         slot[k]    = slot[pick];
         slot[pick] = tmp;
      end
      for (int k = 0; k < WIN; k++)
         queue_item(OP_COMPLETE, base + slot[k]);
      queue_item(OP_NEXT, $urandom);
   endtask

   // Single random item: off-window, below-mark, full-range, no-op, clear and unordered ops
   task automatic send_noise();
      int unsigned     r;
      logic [OP_W-1:0] opc;
      r   = $urandom_range(99, 0);
      opc = OP_W'($urandom_range(OP_COMPLETE, OP_QUERY));
      if (r < 20)
         queue_item(OP_QUERY, mark + $urandom_range(80, 0));
      else if (r < 35)
         queue_item(OP_START, mark + $urandom_range(70, 0));
      else if (r < 45)
         queue_item(OP_ABORT, mark + $urandom_range(70, 0));
      else if (r < 60)
         queue_item(OP_COMPLETE, mark + $urandom_range(70, 0));
      else if (r < 68)
         queue_item(OP_NEXT, $urandom);
      else if (r < 74)
         queue_item(OP_RECOVER, $urandom);
      else if (r < 84)
         queue_item(opc, $urandom);
      else if (r < 92)
         queue_item(opc, mark - 1 - $urandom_range(20, 0), 1'b0);
      else if (r < 96)
         queue_item(OP_NOP, $urandom, 1'b0);
      else
         queue_item(OP_CLEAR, $urandom);
   endtask

   // Stimulus: directed checks, then random phases over several first-id settings
   initial begin
      logic [FIELD_W-1:0] first_id_plan [5];
      bit                 allow_idle;
      first_id_cfg = FIELD_W'(FVI_RESET);
      clear_tracker();
      first_id_plan[0] = '0;
      first_id_plan[1] = '1;
      first_id_plan[2] = $urandom;
      first_id_plan[3] = 32'hFFFF_FFC0;
      first_id_plan[4] = FIELD_W'(FVI_RESET);
      allow_idle = 1'b1;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: search before anything is seen, window edges, mark jumps, recovery
      queue_item(OP_NEXT, '0);
      queue_item(OP_QUERY, '0);
      queue_item(OP_QUERY, '1);
      queue_item(OP_START, 32'd2);
      queue_item(OP_COMPLETE, 32'd3);
      queue_item(OP_COMPLETE, 32'd2);
      queue_item(OP_NEXT, '0);
      queue_item(OP_QUERY, 32'd3);
      queue_item(OP_START, 32'd1);
      queue_item(OP_ABORT, 32'd1);
      queue_item(OP_START, 32'd1);
      queue_item(OP_COMPLETE, 32'd1);
      queue_item(OP_COMPLETE, 32'd0);
      queue_item(OP_START, 32'd68);
      queue_item(OP_ABORT, 32'd68);
      queue_item(OP_COMPLETE, 32'd68);
      queue_item(OP_COMPLETE, 32'd10);
      queue_item(OP_COMPLETE, 32'd20);
      queue_item(OP_RECOVER, '0);
      queue_item(OP_RECOVER, '0);
      queue_item(OP_NOP, $urandom);
      // recover must not move a mark that is already above the highest seen id
      queue_item(OP_CLEAR, '0);
      queue_item(OP_QUERY, 32'd1);
      queue_item(OP_COMPLETE, 32'd1);
      queue_item(OP_COMPLETE, 32'd5);
      queue_item(OP_RECOVER, '0);
      queue_item(OP_QUERY, 32'd5);

      for (int p = 0; p < 5; p++) begin
         write_first_id(first_id_plan[p]);
         phase_items = 0;
         // recover with nothing seen since the clear
         queue_item(OP_CLEAR, $urandom);
         queue_item(OP_COMPLETE, first_id_plan[p] + 3);
         queue_item(OP_RECOVER, $urandom);
         while (phase_items < PHASE_ITEMS) begin
            // stop all idling for the last part of the run
            if (p == 4 && phase_items >= PHASE_ITEMS / 2) begin
               allow_idle   = 1'b0;
               send_idle_on = 1'b0;
               recv_idle_on = 1'b0;
            end
            if ($urandom_range(7, 0) == 0) begin
               send_idle_on = allow_idle && ($urandom_range(3, 0) != 0);
               recv_idle_on = allow_idle && ($urandom_range(3, 0) != 0);
            end
            if (phase_items >= PHASE_ITEMS / 3 && phase_items < PHASE_ITEMS / 3 + 12)
               fill_window();
            else if ($urandom_range(39, 0) == 0)
               wait_drained();
            if ($urandom_range(99, 0) < 60)
               run_batch();
            else
               send_noise();
         end
      end

      // Drain, then give late or extra results time to show up
      wait_sent();
      while (expected_rsp.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
      if (expected_rsp.size() != 0)
         error_count++;
      if (error_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
